@@ src/swtc_pkg.sv @@
// Package for the swerve wheel transition cost block.
// Holds payload structs, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package swtc_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic signed [22:0] PI_Q20 = 23'sd3294199;
  localparam logic signed [17:0] PI_Q13 = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
  localparam logic [19:0] GAIN_Q20 = 20'd636751;
  localparam int unsigned CW = 40;
  localparam int unsigned ZW = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_LENGTH = 3'd0,
    REG_HALF_WIDTH  = 3'd1,
    REG_STEER_EN    = 3'd2,
    REG_UPPER       = 3'd3,
    REG_LOWER       = 3'd4,
    REG_INV_SPEED   = 3'd5,
    REG_INV_ACCEL   = 3'd6,
    REG_INV_STEER   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] succ_vx;
    logic signed [15:0] succ_vy;
    logic signed [15:0] succ_yaw_rate;
    logic               has_predecessor;
    logic signed [15:0] pred_vx;
    logic signed [15:0] pred_vy;
    logic signed [15:0] pred_yaw_rate;
    logic [31:0]        cost_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        cost_out;
    logic signed [15:0] speed_front_left;
    logic signed [15:0] speed_front_right;
    logic signed [15:0] speed_rear_left;
    logic signed [15:0] speed_rear_right;
    logic signed [15:0] angle_front_left;
    logic signed [15:0] angle_front_right;
    logic signed [15:0] angle_rear_left;
    logic signed [15:0] angle_rear_right;
  } out_item_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_q20(input int unsigned i);
    logic signed [ZW-1:0] r;
    r = '0;
    case (i)
      0: r = 25'sd823550;
      1: r = 25'sd486170;
      2: r = 25'sd256879;
      3: r = 25'sd130396;
      4: r = 25'sd65451;
      5: r = 25'sd32757;
      6: r = 25'sd16383;
      7: r = 25'sd8192;
      8: r = 25'sd4096;
      9: r = 25'sd2048;
      10: r = 25'sd1024;
      11: r = 25'sd512;
      12: r = 25'sd256;
      13: r = 25'sd128;
      14: r = 25'sd64;
      15: r = 25'sd32;
      16: r = 25'sd16;
      17: r = 25'sd8;
      18: r = 25'sd4;
      19: r = 25'sd2;
      20: r = 25'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/swtc_cordic_cell.sv @@
// One vectoring CORDIC cell: a single micro-rotation with a register after it.
// Depends on swtc_pkg.
`default_nettype none
module swtc_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic              clk,
  input  wire swtc_pkg::cordic_t in_c,
  output swtc_pkg::cordic_t      out_c
);
  import swtc_pkg::*;

  cordic_t nxt;

  always_comb begin
    nxt = in_c;
    if (in_c.y >= 0) begin
      nxt.x = in_c.x + (in_c.y >>> STAGE);
      nxt.y = in_c.y - (in_c.x >>> STAGE);
      nxt.z = in_c.z + atan_q20(STAGE);
    end else begin
      nxt.x = in_c.x - (in_c.y >>> STAGE);
      nxt.y = in_c.y + (in_c.x >>> STAGE);
      nxt.z = in_c.z - atan_q20(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    out_c <= nxt;
  end
endmodule
`default_nettype wire

@@ src/swtc_wheel.sv @@
// One wheel's command pipeline: wheel vector, CORDIC cell chain, gain and limits.
// Depends on swtc_pkg and swtc_cordic_cell.
`default_nettype none
module swtc_wheel #(
  parameter int unsigned STAGES = swtc_pkg::CORDIC_STAGES_DEF,
  parameter bit          FRONT  = 1'b1,
  parameter bit          LEFT   = 1'b1
) (
  input  wire logic               clk,
  input  wire logic signed [15:0] vx,
  input  wire logic signed [15:0] vy,
  input  wire logic signed [15:0] om,
  input  wire logic [15:0]        half_length,
  input  wire logic [15:0]        half_width,
  input  wire logic               steer_en,
  input  wire logic signed [15:0] upper,
  input  wire logic signed [15:0] lower,
  output logic signed [15:0]      speed,
  output logic signed [15:0]      angle
);
  import swtc_pkg::*;

  logic signed [33:0] ax_r, ay_r;
  cordic_t            c0_nxt, c0_r;
  wire cordic_t       chain [STAGES+1];
  logic signed [CW+21:0] mag_r;
  logic signed [ZW-1:0]  z_r;
  logic                  zero_r;
  logic signed [15:0]    sp_r, an_r;

  logic signed [16:0] px, py;
  logic signed [33:0] ax_nxt, ay_nxt;
  logic signed [19:0] wx, wy;
  logic signed [CW-1:0] xs, ys, xc;
  logic signed [CW+21:0] mprod;
  logic signed [CW+21:0] mround;
  logic signed [CW+21:0] sp_w;
  logic signed [ZW-1:0]  a_w;
  logic signed [17:0]    a18, plus, minus;
  logic                  oob;

  always_comb begin
    px = FRONT ? $signed({1'b0, half_length}) : -$signed({1'b0, half_length});
    py = LEFT ? $signed({1'b0, half_width}) : -$signed({1'b0, half_width});
    ax_nxt = ($signed({{18{vx[15]}}, vx}) <<< 14) - 34'(py * om) + 34'sd8192;
    ay_nxt = ($signed({{18{vy[15]}}, vy}) <<< 14) + 34'(px * om) + 34'sd8192;
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt;
    ay_r <= ay_nxt;
  end

  always_comb begin
    wx = 20'(ax_r >>> 14);
    wy = 20'(ay_r >>> 14);
    xs = CW'(wx) <<< 8;
    ys = CW'(wy) <<< 8;
    c0_nxt.zero = (wx == 0) && (wy == 0);
    if (xs < 0) begin
      c0_nxt.x = -xs;
      c0_nxt.y = -ys;
      c0_nxt.z = (ys >= 0) ? ZW'(PI_Q20) : -ZW'(PI_Q20);
    end else begin
      c0_nxt.x = xs;
      c0_nxt.y = ys;
      c0_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    c0_r <= c0_nxt;
  end

  assign chain[0] = c0_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    swtc_cordic_cell #(.STAGE(i)) u_cell (
      .clk  (clk),
      .in_c (chain[i]),
      .out_c(chain[i+1])
    );
  end

  always_comb begin
    xc = (chain[STAGES].x < 0) ? '0 : chain[STAGES].x;
    mprod = (CW+22)'(xc) * $signed({1'b0, GAIN_Q20});
  end

  always_ff @(posedge clk) begin
    mag_r  <= mprod;
    z_r    <= chain[STAGES].z;
    zero_r <= chain[STAGES].zero;
  end

  always_comb begin
    mround = (mag_r + (CW+22)'(64'sd524288)) >>> 20;
    sp_w = (mround + (CW+22)'(128)) >>> 8;
    a_w = (z_r + ZW'(64)) >>> 7;
    a18 = 18'(a_w);
    if (a18 > PI_Q13) a18 = a18 - TWO_PI_Q13;
    if (a18 <= -PI_Q13) a18 = a18 + TWO_PI_Q13;
  end

  always_ff @(posedge clk) begin
    if (zero_r) begin
      sp_r <= '0;
      an_r <= '0;
    end else begin
      sp_r <= (sp_w > (CW+22)'(32767)) ? 16'sd32767 : 16'(sp_w);
      an_r <= 16'(a18);
    end
  end

  always_comb begin
    plus = 18'(an_r) + PI_Q13;
    minus = 18'(an_r) - PI_Q13;
    if (plus > PI_Q13) plus = plus - TWO_PI_Q13;
    if (minus <= -PI_Q13) minus = minus + TWO_PI_Q13;
    oob = steer_en &&
          ((18'(an_r) > 18'(upper) && plus > 18'(lower)) ||
           (18'(an_r) < 18'(lower) && minus < 18'(upper)));
  end

  always_ff @(posedge clk) begin
    speed <= oob ? -sp_r : sp_r;
    angle <= oob ? 16'(plus) : an_r;
  end
endmodule
`default_nettype wire

@@ src/swtc_isqrt.sv @@
// Pipelined integer square root, one result bit per stage cell.
// Depends on nothing but its parameters; carries a side payload along.
`default_nettype none
module swtc_isqrt #(
  parameter int unsigned IW = 64,
  parameter int unsigned PW = 1
) (
  input  wire logic          clk,
  input  wire logic [IW-1:0] rad,
  input  wire logic [PW-1:0] pin,
  output logic [IW/2-1:0]    root,
  output logic [PW-1:0]      pout
);
  localparam int unsigned N = IW / 2;

  logic [IW-1:0]   rem_r  [N+1];
  logic [N-1:0]    res_r  [N+1];
  logic [PW-1:0]   pay_r  [N+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= rad;
    res_r[0] <= '0;
    pay_r[0] <= pin;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [IW+1:0] trial;
    logic [IW+1:0] cur;
    always_comb begin
      cur = (IW+2)'(rem_r[i] >> (2 * (N - 1 - i)));
      trial = (IW+2)'({res_r[i], 2'b01});
    end
    always_ff @(posedge clk) begin
      pay_r[i+1] <= pay_r[i];
      if (cur >= trial) begin
        rem_r[i+1] <= rem_r[i] - IW'(trial << (2 * (N - 1 - i)));
        res_r[i+1] <= {res_r[i][N-2:0], 1'b1};
      end else begin
        rem_r[i+1] <= rem_r[i];
        res_r[i+1] <= {res_r[i][N-2:0], 1'b0};
      end
    end
  end

  assign root = res_r[N];
  assign pout = pay_r[N];
endmodule
`default_nettype wire

@@ src/swerve_wheel_transition_cost.sv @@
// Top level of the swerve wheel transition cost block.
// Depends on swtc_pkg, swtc_wheel, swtc_isqrt and swtc_cordic_cell.
//
// Usage: drive an item on in_item with start high; it is accepted at that
// edge because busy is always low. The block is a full pipeline and takes
// one transaction per cycle, back to back. Each result appears on out_item
// with out_valid high for exactly one cycle, after acceptance and passage
// through the wheel vector and CORDIC entry registers, the chain of CORDIC
// cells, the gain, rounding and limit registers, the scaling and squaring
// registers, the square root input register and its 34 stages, and the
// output register. The receiver cannot stall. Configuration is written
// through cfg_we, cfg_index and cfg_data while no transaction is in flight;
// the user must keep to this, as the block itself does not enforce it.
// Synchronous reset clears the valid pipeline and loads register defaults.
`default_nettype none
module swerve_wheel_transition_cost #(
  parameter int unsigned CORDIC_STAGES = swtc_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire swtc_pkg::in_item_t                 in_item,
  output logic                                    out_valid,
  output swtc_pkg::out_item_t                     out_item,
  input  wire logic                               cfg_we,
  input  wire logic [swtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [swtc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import swtc_pkg::*;

  localparam int unsigned WL = CORDIC_STAGES + 5;
  localparam int unsigned SQ_W = 68;
  localparam int unsigned LAT = WL + 4 + SQ_W / 2;

  logic [15:0] half_length_r, half_width_r;
  logic        steer_en_r;
  logic [63:0] upper_r, lower_r;
  logic [15:0] inv_speed_r, inv_accel_r, inv_steer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_length_r <= 16'd4096;
      half_width_r  <= 16'd4096;
      steer_en_r    <= 1'b0;
      upper_r       <= '0;
      lower_r       <= '0;
      inv_speed_r   <= 16'd256;
      inv_accel_r   <= 16'd256;
      inv_steer_r   <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HALF_LENGTH: half_length_r <= cfg_data[15:0];
        REG_HALF_WIDTH:  half_width_r  <= cfg_data[15:0];
        REG_STEER_EN:    steer_en_r    <= cfg_data[0];
        REG_UPPER:       upper_r       <= cfg_data;
        REG_LOWER:       lower_r       <= cfg_data;
        REG_INV_SPEED:   inv_speed_r   <= cfg_data[15:0];
        REG_INV_ACCEL:   inv_accel_r   <= cfg_data[15:0];
        REG_INV_STEER:   inv_steer_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], accept};
  end
  assign out_valid = vld_r[LAT-1];

  wire logic signed [15:0] ss [4], sa [4], ps [4], pa [4];

  for (genvar w = 0; w < 4; w++) begin : g_wheel
    swtc_wheel #(.STAGES(CORDIC_STAGES), .FRONT(w < 2), .LEFT((w % 2) == 0)) u_succ (
      .clk(clk), .vx(in_item.succ_vx), .vy(in_item.succ_vy), .om(in_item.succ_yaw_rate),
      .half_length(half_length_r), .half_width(half_width_r), .steer_en(steer_en_r),
      .upper(upper_r[16*w +: 16]), .lower(lower_r[16*w +: 16]),
      .speed(ss[w]), .angle(sa[w]));
    swtc_wheel #(.STAGES(CORDIC_STAGES), .FRONT(w < 2), .LEFT((w % 2) == 0)) u_pred (
      .clk(clk), .vx(in_item.pred_vx), .vy(in_item.pred_vy), .om(in_item.pred_yaw_rate),
      .half_length(half_length_r), .half_width(half_width_r), .steer_en(steer_en_r),
      .upper(upper_r[16*w +: 16]), .lower(lower_r[16*w +: 16]),
      .speed(ps[w]), .angle(pa[w]));
  end

  // Side data delayed to line up with the wheel outputs.
  logic [31:0]        cost_d   [WL];
  logic               hp_d     [WL];
  logic signed [15:0] vx_d     [WL];
  logic signed [15:0] vy_d     [WL];
  logic signed [15:0] om_d     [WL];

  always_ff @(posedge clk) begin
    cost_d[0] <= in_item.cost_in;
    hp_d[0]   <= in_item.has_predecessor;
    vx_d[0]   <= in_item.succ_vx;
    vy_d[0]   <= in_item.succ_vy;
    om_d[0]   <= in_item.succ_yaw_rate;
    for (int k = 1; k < WL; k++) begin
      cost_d[k] <= cost_d[k-1];
      hp_d[k]   <= hp_d[k-1];
      vx_d[k]   <= vx_d[k-1];
      vy_d[k]   <= vy_d[k-1];
      om_d[k]   <= om_d[k-1];
    end
  end

  // Scale stage: scaled differences and body terms.
  logic [33:0] sa_r [4], sb_r [4];
  logic [32:0] body_sq_r;
  logic [31:0] wcost_r;
  logic [31:0] cost_s1_r;
  logic        hp_s1_r;
  logic [15:0] ssp_s1_r [4], sag_s1_r [4];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      logic signed [17:0] ds, da;
      logic [16:0] ua, ub;
      ds = 18'(ss[k]) - 18'(ps[k]);
      da = 18'(sa[k]) - 18'(pa[k]);
      ua = 17'(ds < 0 ? -ds : ds);
      ub = 17'(da < 0 ? -da : da);
      sa_r[k] <= 34'((ua * inv_accel_r + 34'd2) >> 2);
      sb_r[k] <= 34'((ub * inv_steer_r + 34'd16) >> 5);
      ssp_s1_r[k] <= ss[k];
      sag_s1_r[k] <= sa[k];
    end
    body_sq_r <= 33'(vx_d[WL-1] * vx_d[WL-1]) + 33'(vy_d[WL-1] * vy_d[WL-1]);
    wcost_r   <= 32'(((om_d[WL-1] < 0 ? 17'(-om_d[WL-1]) : 17'(om_d[WL-1]))
                     * inv_steer_r + 33'd8) >> 4);
    cost_s1_r <= cost_d[WL-1];
    hp_s1_r   <= hp_d[WL-1];
  end

  // Square stage.
  logic [64:0] tsq_r [4];
  logic [64:0] bsq_r;
  logic [31:0] cost_s2_r, wcost_s2_r;
  logic        hp_s2_r;
  logic [15:0] ssp_s2_r [4], sag_s2_r [4];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      tsq_r[k] <= 65'(sa_r[k] * sa_r[k]) + 65'(sb_r[k] * sb_r[k]);
      ssp_s2_r[k] <= ssp_s1_r[k];
      sag_s2_r[k] <= sag_s1_r[k];
    end
    bsq_r      <= 65'({body_sq_r, 16'h0000});
    cost_s2_r  <= cost_s1_r;
    wcost_s2_r <= wcost_r;
    hp_s2_r    <= hp_s1_r;
  end

  // Each root pipeline carries part of the side data along.
  wire logic [SQ_W/2-1:0] root [5];
  logic [31:0] p_cost, p_wcost;
  logic        p_hp;
  logic [63:0] p_spd, p_ang;

  swtc_isqrt #(.IW(SQ_W), .PW(32)) u_sq0 (.clk(clk), .rad(SQ_W'(tsq_r[0])),
    .pin(cost_s2_r), .root(root[0]), .pout(p_cost));
  swtc_isqrt #(.IW(SQ_W), .PW(32)) u_sq1 (.clk(clk), .rad(SQ_W'(tsq_r[1])),
    .pin(wcost_s2_r), .root(root[1]), .pout(p_wcost));
  swtc_isqrt #(.IW(SQ_W), .PW(64)) u_sq2 (.clk(clk), .rad(SQ_W'(tsq_r[2])),
    .pin({ssp_s2_r[0], ssp_s2_r[1], ssp_s2_r[2], ssp_s2_r[3]}),
    .root(root[2]), .pout(p_spd));
  swtc_isqrt #(.IW(SQ_W), .PW(64)) u_sq3 (.clk(clk), .rad(SQ_W'(tsq_r[3])),
    .pin({sag_s2_r[0], sag_s2_r[1], sag_s2_r[2], sag_s2_r[3]}),
    .root(root[3]), .pout(p_ang));
  swtc_isqrt #(.IW(SQ_W), .PW(1)) u_sq4 (.clk(clk), .rad(SQ_W'(bsq_r)),
    .pin(hp_s2_r), .root(root[4]), .pout(p_hp));

  // Final combine; tables of width kept within one multiply and compare.
  logic [49:0] vcost;
  logic [49:0] wb, tmax, step;
  logic [50:0] total;

  always_comb begin
    vcost = 50'((root[4] * inv_speed_r + 50'd512) >> 10);
    wb = (vcost > 50'(p_wcost)) ? vcost : 50'(p_wcost);
    tmax = 50'(root[0]);
    for (int k = 1; k < 4; k++) begin
      if (50'(root[k]) > tmax) tmax = 50'(root[k]);
    end
    step = (p_hp && tmax > wb) ? tmax : wb;
    total = 51'(p_cost) + 51'(step);
  end

  always_ff @(posedge clk) begin
    out_item.cost_out <= (total > 51'h0FFFFFFFF) ? 32'hFFFFFFFF : total[31:0];
    {out_item.speed_front_left, out_item.speed_front_right,
     out_item.speed_rear_left, out_item.speed_rear_right,
     out_item.angle_front_left, out_item.angle_front_right,
     out_item.angle_rear_left, out_item.angle_rear_right} <= {p_spd, p_ang};
  end
endmodule
`default_nettype wire
